// ===== hdl/rbcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbcc_pkg
// Shared types and constants for the comparison-count ranking block.
// ----------------------------------------------------------------------------
package rbcc_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int RANK_W    = 6;

    // front-to-back command queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               final_item;
    } t_in_req;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              last_rank;
        logic              overflow;
    } t_out_req;

    // classified item, as handed from front to back
    typedef struct packed {
        logic signed [31:0] value;
        logic [ADDR_W-1:0]  addr;      // store slot
        logic               store;     // write value into the store
        logic               close;     // set ends here, start ranking
        logic               ovf;       // set overflowed (valid with close)
        logic [CNT_W-1:0]   n;         // stored count (valid with close)
    } t_cmd;

endpackage

// ===== hdl/rbcc_front.sv =====
// ----------------------------------------------------------------------------
// rbcc_front
// Accepts requests, assigns store slots, tracks set size and overflow.
// ----------------------------------------------------------------------------
module rbcc_front import rbcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in_req i_in_data,
    input  logic    i_q_full,
    output logic    o_q_push,
    output t_cmd    o_q_cmd
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             store;

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign store      = (r_count < CNT_W'(MAX_ITEMS));

    always_comb begin
        o_q_cmd.value = i_in_data.sample_value;
        o_q_cmd.addr  = r_count[ADDR_W-1:0];
        o_q_cmd.store = store;
        o_q_cmd.close = i_in_data.final_item;
        o_q_cmd.ovf   = r_ovf || !store;
        o_q_cmd.n     = store ? r_count + 1'b1 : r_count;
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (o_q_push) begin
            if (i_in_data.final_item) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = o_q_cmd.n;
                n_ovf   = o_q_cmd.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== hdl/rbcc_queue.sv =====
// ----------------------------------------------------------------------------
// rbcc_queue
// Small FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module rbcc_queue import rbcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rbcc_back.sv =====
// ----------------------------------------------------------------------------
// rbcc_back
// Value store and ranking sequencer: one comparator sweeps the store
// for each stored value, results leave through an output register.
// ----------------------------------------------------------------------------
module rbcc_back import rbcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_head,
    input  logic     i_empty,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SELF = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic signed [31:0] r_store [MAX_ITEMS];
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_self, n_self;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic              r_out_vld, n_out_vld;
    t_out_req          r_out, n_out;
    logic              lt, is_last;

    assign lt          = (r_rd_data < r_self);
    assign is_last     = ({1'b0, r_i} == CNT_W'(r_n - 1'b1));
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[i_head.addr] <= i_head.value;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_k       = r_k;
        n_i       = r_i;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_self    = r_self;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        rd_addr   = r_i;
        mem_we    = 1'b0;
        o_pop     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    mem_we = i_head.store;
                    if (i_head.close) begin
                        n_n     = i_head.n;
                        n_ovf   = i_head.ovf;
                        n_i     = '0;
                        n_state = S_SELF;
                    end
                end
            end
            S_SELF: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // own value arrives; start the sweep at slot 0
                n_self  = r_rd_data;
                rd_addr = '0;
                n_k     = CNT_W'(1);
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_cnt = r_cnt + ADDR_W'(lt);
                if (r_k == r_n) begin
                    n_state = S_EMIT;
                end else begin
                    rd_addr = r_k[ADDR_W-1:0];
                    n_k     = r_k + 1'b1;
                end
            end
            S_EMIT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld       = 1'b1;
                    n_out.rank      = RANK_W'(r_cnt);
                    n_out.last_rank = is_last;
                    n_out.overflow  = r_ovf;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_SELF;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_k    <= n_k;
        r_i    <= n_i;
        r_cnt  <= n_cnt;
        r_ovf  <= n_ovf;
        r_self <= n_self;
        r_out  <= n_out;
    end

endmodule

// ===== hdl/rank_by_comparison_count_top.sv =====
// ----------------------------------------------------------------------------
// rank_by_comparison_count_top
// Ranks a set of signed 32-bit values by counting, for each value, how many
// values of the set are strictly smaller. Values arrive one request at a
// time with the last one marked by final_item; up to MAX_ITEMS (64) are
// kept and later ones are dropped, which raises overflow on every result of
// that set. After the marked request the block returns one result per
// stored value in arrival order, with last_rank on the final one. Equal
// values get equal ranks. The front side takes one input request per cycle
// into a 4-deep command queue while the queue has room. The back side owns
// the value store and a single comparator: for a set of n stored values,
// each result takes an own-value read, a load, n compares and an output
// step, and while a set is being ranked further input requests only fill
// the queue. Results sit in an output register and the back side stalls
// only when that register is still full.
// ----------------------------------------------------------------------------
module rank_by_comparison_count_top import rbcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    // front -> queue
    logic q_push;
    t_cmd q_cmd;
    logic q_full;

    // queue -> back
    t_cmd q_head;
    logic q_empty;
    logic q_pop;

    rbcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_cmd)
    );

    rbcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // store writes and the ranking sweep run here, in queue order
    rbcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
